@@ rtl/dcmb_pkg.sv @@
// ----------------------------------------------------------------------------
// dcmb_pkg
// Shared types and port codes for the dual processor mailbox and I/O ports.
// ----------------------------------------------------------------------------
package dcmb_pkg;

    // access side and direction codes
    localparam logic SIDE_MAIN  = 1'b0;
    localparam logic SIDE_IO    = 1'b1;
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // main side port addresses
    localparam logic [7:0] PORT_MAIN_TO_IO   = 8'h40;
    localparam logic [7:0] PORT_MAIN_BANK    = 8'h60;
    localparam logic [7:0] PORT_MAIN_RD_BOX  = 8'h41;
    localparam logic [7:0] PORT_MAIN_STATUS  = 8'h42;

    // i/o side port addresses
    localparam logic [7:0] PORT_IO_TO_MAIN   = 8'h21;
    localparam logic [7:0] PORT_IO_PSG0      = 8'h40;
    localparam logic [7:0] PORT_IO_PSG1      = 8'h44;
    localparam logic [7:0] PORT_IO_PSG2      = 8'h46;
    localparam logic [7:0] PORT_IO_SEL0      = 8'h41;
    localparam logic [7:0] PORT_IO_SEL1      = 8'h43;
    localparam logic [7:0] PORT_IO_SEL2      = 8'h45;
    localparam logic [7:0] PORT_IO_SEL3      = 8'h47;
    localparam logic [7:0] PORT_IO_EMPTY     = 8'h10;
    localparam logic [7:0] PORT_IO_RD_BOX    = 8'h20;
    localparam logic [7:0] PORT_IO_STATUS    = 8'h22;
    localparam logic [7:0] PORT_IO_JOY       = 8'h40;
    localparam logic [7:0] PORT_IO_DSW       = 8'h44;

    // sound chip numbers
    localparam logic [1:0] PSG_CHIP0 = 2'd0;
    localparam logic [1:0] PSG_CHIP1 = 2'd1;
    localparam logic [1:0] PSG_CHIP2 = 2'd2;

    // select latch bits that enable the input reads
    localparam logic [7:0] SEL_GATE_MASK = 8'h0e;
    localparam logic [7:0] DSW_VALUE     = 8'hff;
    localparam int         SEL_DEPTH     = 4;

    typedef struct packed {
        logic       side;
        logic       func;
        logic [7:0] port_addr;
        logic [7:0] wdata;
        logic [7:0] joy_byte;
        logic [7:0] coin_byte;
    } t_req;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq_to_io;
        logic       psg_wr;
        logic [1:0] psg_chip;
        logic [7:0] psg_reg;
        logic [7:0] psg_data;
        logic [7:0] bank_out;
        logic       io_box_full;
    } t_rsp;

endpackage

@@ rtl/dcmb_req_if.sv @@
// ----------------------------------------------------------------------------
// dcmb_req_if
// Valid/ready channel carrying one port access request.
// ----------------------------------------------------------------------------
interface dcmb_req_if;
    logic           valid;
    logic           ready;
    dcmb_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/dcmb_rsp_if.sv @@
// ----------------------------------------------------------------------------
// dcmb_rsp_if
// Valid/ready channel carrying one access result.
// ----------------------------------------------------------------------------
interface dcmb_rsp_if;
    logic           valid;
    logic           ready;
    dcmb_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/dual_cpu_mailbox_io_ports.sv @@
// ----------------------------------------------------------------------------
// dual_cpu_mailbox_io_ports
// Port decode for a main and an i/o processor sharing two byte mailboxes,
// sound chip select latches and a graphics bank latch.
// ----------------------------------------------------------------------------
// Each request is one port access from either processor. Its result is
// registered in the cycle after the request is taken, and a new request is
// taken in every cycle while the result register is empty or being drained,
// so the block sustains one access per clock. The single result register
// sets that figure: when the result sink stalls, requests stall with it.
// Mailbox flags, select latches and the bank latch update as the request is
// taken; the result reports the bank latch and main-to-i/o flag after it.
// ----------------------------------------------------------------------------
module dual_cpu_mailbox_io_ports (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dcmb_req_if.sink    i_req,
    dcmb_rsp_if.source  o_rsp
);
    import dcmb_pkg::*;

    logic   r_rsp_valid;
    t_rsp   r_rsp;
    t_rsp   core_rsp;
    logic   req_take;

    // take a request when the result register is free or draining
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign req_take    = i_req.valid && i_req.ready;

    dcmb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (req_take),
        .i_req   (i_req.data),
        .o_rsp   (core_rsp)
    );

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (req_take) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_rsp <= core_rsp;
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

endmodule

@@ rtl/dcmb_core.sv @@
// ----------------------------------------------------------------------------
// dcmb_core
// Mailbox, select latch and bank latch state with the port decode for one
// access; state updates when i_en is high.
// ----------------------------------------------------------------------------
module dcmb_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  dcmb_pkg::t_req i_req,
    output dcmb_pkg::t_rsp o_rsp
);
    import dcmb_pkg::*;

    logic [7:0] r_to_io_box,   n_to_io_box;
    logic [7:0] r_to_main_box, n_to_main_box;
    logic       r_to_io_full,  n_to_io_full;
    logic       r_to_main_full, n_to_main_full;
    logic [7:0] r_sel_latch [SEL_DEPTH];
    logic [7:0] n_sel_latch [SEL_DEPTH];
    logic [7:0] r_gfx_bank,    n_gfx_bank;

    logic [1:0] sel_idx;
    logic       joy_gate;
    logic       dsw_gate;

    assign sel_idx  = i_req.port_addr[2:1];
    assign joy_gate = (r_sel_latch[0] & SEL_GATE_MASK) == SEL_GATE_MASK;
    assign dsw_gate = (r_sel_latch[2] & SEL_GATE_MASK) == SEL_GATE_MASK;

    // port decode and next state
    always_comb begin
        n_to_io_box    = r_to_io_box;
        n_to_main_box  = r_to_main_box;
        n_to_io_full   = r_to_io_full;
        n_to_main_full = r_to_main_full;
        n_gfx_bank     = r_gfx_bank;
        for (int i = 0; i < SEL_DEPTH; i++) begin
            n_sel_latch[i] = r_sel_latch[i];
        end
        o_rsp = '0;

        if (i_req.side == SIDE_MAIN) begin
            if (i_req.func == FUNC_WRITE) begin
                case (i_req.port_addr)
                    PORT_MAIN_TO_IO: begin
                        n_to_io_full    = 1'b1;
                        n_to_io_box     = i_req.wdata;
                        o_rsp.irq_to_io = 1'b1;
                    end
                    PORT_MAIN_BANK: begin
                        n_gfx_bank = i_req.wdata;
                    end
                    default: begin
                    end
                endcase
            end else begin
                case (i_req.port_addr)
                    PORT_MAIN_RD_BOX: begin
                        n_to_main_full = 1'b0;
                        o_rsp.rdata    = r_to_main_box;
                    end
                    PORT_MAIN_STATUS: begin
                        // status with the main-to-i/o flag inverted
                        o_rsp.rdata = {4'b0, ~r_to_io_full, 2'b0, r_to_main_full};
                    end
                    default: begin
                    end
                endcase
            end
        end else begin
            if (i_req.func == FUNC_WRITE) begin
                case (i_req.port_addr)
                    PORT_IO_TO_MAIN: begin
                        n_to_main_full = 1'b1;
                        n_to_main_box  = i_req.wdata;
                    end
                    PORT_IO_PSG0: begin
                        o_rsp.psg_wr   = 1'b1;
                        o_rsp.psg_chip = PSG_CHIP0;
                        o_rsp.psg_reg  = r_sel_latch[0];
                        o_rsp.psg_data = i_req.wdata;
                    end
                    PORT_IO_PSG1: begin
                        o_rsp.psg_wr   = 1'b1;
                        o_rsp.psg_chip = PSG_CHIP1;
                        o_rsp.psg_reg  = r_sel_latch[2];
                        o_rsp.psg_data = i_req.wdata;
                    end
                    PORT_IO_PSG2: begin
                        o_rsp.psg_wr   = 1'b1;
                        o_rsp.psg_chip = PSG_CHIP2;
                        o_rsp.psg_reg  = r_sel_latch[3];
                        o_rsp.psg_data = i_req.wdata;
                    end
                    PORT_IO_SEL0, PORT_IO_SEL1, PORT_IO_SEL2, PORT_IO_SEL3: begin
                        n_sel_latch[sel_idx] = i_req.wdata;
                    end
                    default: begin
                    end
                endcase
            end else begin
                case (i_req.port_addr)
                    PORT_IO_EMPTY: begin
                        o_rsp.rdata = {7'b0, ~r_to_io_full};
                    end
                    PORT_IO_RD_BOX: begin
                        n_to_io_full = 1'b0;
                        o_rsp.rdata  = r_to_io_box;
                    end
                    PORT_IO_STATUS: begin
                        // status with the i/o-to-main flag inverted
                        o_rsp.rdata = {4'b0, r_to_io_full, 2'b0, ~r_to_main_full};
                    end
                    PORT_IO_JOY: begin
                        // latch bit 0 picks the player byte or the coin byte
                        if (joy_gate) begin
                            o_rsp.rdata = r_sel_latch[0][0] ? i_req.joy_byte
                                                            : i_req.coin_byte;
                        end
                    end
                    PORT_IO_DSW: begin
                        if (dsw_gate) begin
                            o_rsp.rdata = DSW_VALUE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        // latch values after this access
        o_rsp.bank_out    = n_gfx_bank;
        o_rsp.io_box_full = n_to_io_full;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_to_io_box    <= '0;
            r_to_main_box  <= '0;
            r_to_io_full   <= 1'b0;
            r_to_main_full <= 1'b0;
            r_gfx_bank     <= '0;
            for (int i = 0; i < SEL_DEPTH; i++) begin
                r_sel_latch[i] <= '0;
            end
        end else if (i_en) begin
            r_to_io_box    <= n_to_io_box;
            r_to_main_box  <= n_to_main_box;
            r_to_io_full   <= n_to_io_full;
            r_to_main_full <= n_to_main_full;
            r_gfx_bank     <= n_gfx_bank;
            for (int i = 0; i < SEL_DEPTH; i++) begin
                r_sel_latch[i] <= n_sel_latch[i];
            end
        end
    end

endmodule
